// ===== rtl/box_iou_macros.svh =====
// Assertion macros shared by the box IoU RTL.
`ifndef BOX_IOU_MACROS_SVH
`define BOX_IOU_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BIOU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("box_iou: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIOU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("box_iou: next-cycle check failed");

`else

`define BIOU_ASSERT_IMP(lbl, ante, cons)
`define BIOU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/biou_pkg.sv =====
// Types and fixed constants shared by the box IoU modules.
package biou_pkg;

    // Control tag that travels alongside each item between the parts.
    typedef struct packed {
        logic vld;
        logic empty_union;
    } t_tag;

    // Number of entries in the queue between the front and the divider.
    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/biou_front.sv =====
// Front part: overlap spans, areas and union of a box pair, in three register stages.
module biou_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [COORD_BITS-1:0]     i_a_left,
    input  logic [COORD_BITS-1:0]     i_a_top,
    input  logic [COORD_BITS-1:0]     i_a_width,
    input  logic [COORD_BITS-1:0]     i_a_height,
    input  logic [COORD_BITS-1:0]     i_b_left,
    input  logic [COORD_BITS-1:0]     i_b_top,
    input  logic [COORD_BITS-1:0]     i_b_width,
    input  logic [COORD_BITS-1:0]     i_b_height,
    input  logic                      i_full,
    output logic                      o_stall,
    output biou_pkg::t_tag            o_tag,
    output logic [2*COORD_BITS-1:0]   o_inter,
    output logic [2*COORD_BITS:0]     o_uni
);

    localparam int EW = COORD_BITS + 1;
    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;

    logic                  r_v1, r_v2, r_v3;
    logic [COORD_BITS-1:0] r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic [AW-1:0]         r_inter2, r_aa, r_ab;
    logic [AW-1:0]         r_inter3;
    logic [UW-1:0]         r_uni3;
    logic                  r_flag3;

    logic                  advance;
    logic [EW-1:0]         x_lo, x_hi, y_lo, y_hi;
    logic [EW-1:0]         a_right, b_right, a_bottom, b_bottom;
    logic [COORD_BITS-1:0] n_iw, n_ih;
    logic [UW-1:0]         n_uni;

    // The whole front holds while the last stage cannot enter a full queue.
    assign o_stall = r_v3 && i_full;
    assign advance = !o_stall;

    // Edges and clamped overlap spans of the two boxes.
    always_comb begin
        a_right  = {1'b0, i_a_left} + {1'b0, i_a_width};
        b_right  = {1'b0, i_b_left} + {1'b0, i_b_width};
        a_bottom = {1'b0, i_a_top}  + {1'b0, i_a_height};
        b_bottom = {1'b0, i_b_top}  + {1'b0, i_b_height};
        x_lo = (i_a_left > i_b_left) ? {1'b0, i_a_left} : {1'b0, i_b_left};
        y_lo = (i_a_top  > i_b_top)  ? {1'b0, i_a_top}  : {1'b0, i_b_top};
        x_hi = (a_right  < b_right)  ? a_right  : b_right;
        y_hi = (a_bottom < b_bottom) ? a_bottom : b_bottom;
        n_iw = (x_hi > x_lo) ? COORD_BITS'(x_hi - x_lo) : '0;
        n_ih = (y_hi > y_lo) ? COORD_BITS'(y_hi - y_lo) : '0;
    end

    // Union of the two areas less the shared part.
    assign n_uni = UW'(r_aa) + UW'(r_ab) - UW'(r_inter2);

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads: spans, then products, then union.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_iw     <= n_iw;
            r_ih     <= n_ih;
            r_aw     <= i_a_width;
            r_ah     <= i_a_height;
            r_bw     <= i_b_width;
            r_bh     <= i_b_height;
            r_inter2 <= r_iw * r_ih;
            r_aa     <= r_aw * r_ah;
            r_ab     <= r_bw * r_bh;
            r_inter3 <= r_inter2;
            r_uni3   <= n_uni;
            r_flag3  <= (n_uni == '0);
        end
    end

    assign o_tag.vld         = r_v3;
    assign o_tag.empty_union = r_flag3;
    assign o_inter           = r_inter3;
    assign o_uni             = r_uni3;

endmodule

// ===== rtl/biou_queue.sv =====
// Short queue between the front part and the divider.
`include "box_iou_macros.svh"

module biou_queue #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  biou_pkg::t_tag   i_tag,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output biou_pkg::t_tag   o_tag,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = biou_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH:0]  r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr, n_rd;
    logic            empty, push, pop;

    assign empty  = (r_count == '0);
    assign o_full = (r_count == CW'(DEPTH));
    assign push   = i_tag.vld && !o_full;
    // The divider never stalls, so the head item leaves as soon as it is there.
    assign pop    = !empty;

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= {i_tag.empty_union, i_data};
        end
    end

    assign o_tag.vld         = !empty;
    assign o_tag.empty_union = r_mem[r_rd][WIDTH];
    assign o_data            = r_mem[r_rd][WIDTH-1:0];

    `BIOU_ASSERT_IMP(a_no_push_when_full, i_tag.vld && o_full, !push)
    `BIOU_ASSERT_NXT(a_count_up, push && !pop, r_count == $past(r_count) + 1'b1)
    `BIOU_ASSERT_NXT(a_count_down, pop && !push, r_count == $past(r_count) - 1'b1)

endmodule

// ===== rtl/biou_div.sv =====
// Back part: pipelined restoring divider, one quotient bit per stage, with rounding.
`include "box_iou_macros.svh"

module biou_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  biou_pkg::t_tag          i_tag,
    input  logic [2*COORD_BITS-1:0] i_inter,
    input  logic [2*COORD_BITS:0]   i_uni,
    output logic                    o_valid,
    output logic [FRAC_BITS:0]      o_iou_ratio,
    output logic                    o_empty_union
);

    localparam int AW  = 2 * COORD_BITS;
    localparam int UW  = AW + 1;
    localparam int RW  = FRAC_BITS + 1;
    localparam int NW  = AW + FRAC_BITS + 1;
    localparam int LAT = RW + 1;

    // Stage s of rem/low/uni feeds quotient step s; q[k] holds k+1 quotient bits.
    logic [RW:0]     r_v;
    logic            r_flag [RW+1];
    logic [UW-1:0]   r_rem  [RW];
    logic [RW-1:0]   r_low  [RW];
    logic [UW-1:0]   r_uni  [RW];
    logic [RW-1:0]   r_q    [RW];

    logic [NW-1:0]   n_num;
    logic [UW:0]     t_ext  [RW];
    logic [RW-1:0]   ge;
    logic [UW-1:0]   n_rem  [RW];
    logic [RW-1:0]   n_low  [RW];
    logic [RW-1:0]   n_q    [RW];

    // Rounded numerator: intersection scaled up plus half the union.
    assign n_num = (NW'(i_inter) << FRAC_BITS) + NW'(i_uni >> 1);

    // One trial subtraction per stage; the top numerator bits seed the remainder.
    always_comb begin
        for (int s = 0; s < RW; s++) begin
            t_ext[s] = {r_rem[s], r_low[s][RW-1]};
            ge[s]    = (t_ext[s] >= {1'b0, r_uni[s]});
        end
        n_rem[0] = UW'(n_num[NW-1:RW]);
        n_low[0] = n_num[RW-1:0];
        for (int s = 1; s < RW; s++) begin
            n_rem[s] = ge[s-1] ? UW'(t_ext[s-1] - {1'b0, r_uni[s-1]}) : t_ext[s-1][UW-1:0];
            n_low[s] = {r_low[s-1][RW-2:0], 1'b0};
        end
        n_q[0] = {{(RW-1){1'b0}}, ge[0]};
        for (int k = 1; k < RW; k++) begin
            n_q[k] = {r_q[k-1][RW-2:0], ge[k]};
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[RW-1:0], i_tag.vld};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        r_flag[0] <= i_tag.empty_union;
        r_uni[0]  <= i_uni;
        for (int s = 1; s <= RW; s++) begin
            r_flag[s] <= r_flag[s-1];
        end
        for (int s = 1; s < RW; s++) begin
            r_uni[s] <= r_uni[s-1];
        end
        for (int s = 0; s < RW; s++) begin
            r_rem[s] <= n_rem[s];
            r_low[s] <= n_low[s];
            r_q[s]   <= n_q[s];
        end
    end

    // An empty union forces the ratio to zero.
    assign o_valid       = r_v[RW];
    assign o_empty_union = r_flag[RW];
    assign o_iou_ratio   = r_flag[RW] ? '0 : r_q[RW-1];

    `BIOU_ASSERT_IMP(a_fixed_latency, o_valid, $past(i_tag.vld, LAT))

endmodule

// ===== rtl/box_iou.sv =====
// Top level of the box intersection-over-union unit.
//
// Computes the intersection over union of two axis-aligned boxes as an unsigned
// fraction with FRAC_BITS fraction bits, rounded to nearest with ties up; 1 << FRAC_BITS
// means 1.0. When both boxes have zero area the ratio is 0 and o_empty_union is set.
// An item is taken at each clock edge where start is high and busy is low, one item
// per cycle. Its result shows on the o_ ports for exactly one cycle, marked by
// o_valid, after the three front stages, the queue's entry register and a divider
// of FRAC_BITS + 2 stages that yields one quotient bit per trial subtraction.
// Results cannot be held off. Busy is high only while the four-entry queue ahead of
// the divider is full; the divider drains one entry every cycle, so the queue never
// holds more than one entry and busy stays low.
`include "box_iou_macros.svh"

module box_iou #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_a_left,
    input  logic [COORD_BITS-1:0] i_a_top,
    input  logic [COORD_BITS-1:0] i_a_width,
    input  logic [COORD_BITS-1:0] i_a_height,
    input  logic [COORD_BITS-1:0] i_b_left,
    input  logic [COORD_BITS-1:0] i_b_top,
    input  logic [COORD_BITS-1:0] i_b_width,
    input  logic [COORD_BITS-1:0] i_b_height,
    output logic                  o_valid,
    output logic [FRAC_BITS:0]    o_iou_ratio,
    output logic                  o_empty_union
);

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;
    localparam int QW = AW + UW;
    localparam int RW = FRAC_BITS + 1;
    localparam logic [RW-1:0] RATIO_ONE = RW'(1) << FRAC_BITS;

    biou_pkg::t_tag  fe_tag, q_tag;
    logic [AW-1:0]   fe_inter, q_inter;
    logic [UW-1:0]   fe_uni, q_uni;
    logic [QW-1:0]   q_data;
    logic            q_full;

    // Front: spans, areas and union.
    biou_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_width  (i_a_width),
        .i_a_height (i_a_height),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_width  (i_b_width),
        .i_b_height (i_b_height),
        .i_full     (q_full),
        .o_stall    (busy),
        .o_tag      (fe_tag),
        .o_inter    (fe_inter),
        .o_uni      (fe_uni)
    );

    // Queue between the front and the divider.
    biou_queue #(
        .WIDTH   (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (fe_tag),
        .i_data  ({fe_inter, fe_uni}),
        .o_full  (q_full),
        .o_tag   (q_tag),
        .o_data  (q_data)
    );

    assign q_inter = q_data[QW-1:UW];
    assign q_uni   = q_data[UW-1:0];

    // Back: divider and result strobe.
    biou_div #(
        .COORD_BITS    (COORD_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (q_tag),
        .i_inter       (q_inter),
        .i_uni         (q_uni),
        .o_valid       (o_valid),
        .o_iou_ratio   (o_iou_ratio),
        .o_empty_union (o_empty_union)
    );

    `BIOU_ASSERT_IMP(a_empty_gives_zero, o_valid && o_empty_union, o_iou_ratio == '0)
    `BIOU_ASSERT_IMP(a_ratio_at_most_one, o_valid, o_iou_ratio <= RATIO_ONE)

endmodule
